@@ rtl/s0d_pkg.sv @@
// Shared types, constants and helpers for the SHA-0 style block digest.
// Depends on nothing; every other file of the block imports it.
package s0d_pkg;

   localparam int WORD_W      = 32;
   localparam int BLOCK_WORDS = 16;
   localparam int ADDR_W      = $clog2(BLOCK_WORDS);
   localparam int ROUNDS      = 80;
   localparam int RND_W       = $clog2(ROUNDS + 1);
   localparam int PHASE_LEN   = 20;
   localparam int CHAIN_WORDS = 5;

   typedef logic [WORD_W-1:0]                  word_type;
   typedef logic [ADDR_W-1:0]                  addr_type;
   typedef logic [RND_W-1:0]                   rnd_type;
   typedef logic [CHAIN_WORDS-1:0][WORD_W-1:0] chain_type;

   // Request opcodes.
   localparam logic OP_RESTART = 1'b0;
   localparam logic OP_WORD    = 1'b1;

   // Round function groups, twenty rounds each.
   typedef enum logic [1:0] {
      PH_CHOOSE    = 2'd0,
      PH_PARITY_LO = 2'd1,
      PH_MAJORITY  = 2'd2,
      PH_PARITY_HI = 2'd3
   } phase_type;

   localparam word_type ROUND_K [4] = '{
      32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'hca62c1d6
   };

   localparam chain_type INIT_CHAIN = {
      32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
   };

   // Control from the sequencer to the round datapath.
   typedef struct packed {
      logic      restart;
      logic      load;
      logic      step;
      logic      finish;
      phase_type phase;
      phase_type phase_next;
   } rnd_ctl_type;

   // Message word write into the schedule store.
   typedef struct packed {
      logic     wr_en;
      addr_type wr_addr;
      word_type wr_data;
   } coll_wr_type;

   function automatic phase_type round_phase(input rnd_type r);
      phase_type p;
      priority if (r < RND_W'(PHASE_LEN)) begin
         p = PH_CHOOSE;
      end else if (r < RND_W'(2 * PHASE_LEN)) begin
         p = PH_PARITY_LO;
      end else if (r < RND_W'(3 * PHASE_LEN)) begin
         p = PH_MAJORITY;
      end else begin
         p = PH_PARITY_HI;
      end
      return p;
   endfunction

endpackage

@@ rtl/s0d_if.sv @@
// Valid/ready channel interfaces for the request and response sides.
// Depends on s0d_pkg for the payload types.
interface s0d_req_if;
   import s0d_pkg::*;
   logic     valid;
   logic     ready;
   logic     op;
   word_type msg_word;
   modport source (output valid, output op, output msg_word, input ready);
   modport sink (input valid, input op, input msg_word, output ready);
endinterface

interface s0d_rsp_if;
   import s0d_pkg::*;
   logic     valid;
   logic     ready;
   word_type digest_0;
   word_type digest_1;
   word_type digest_2;
   word_type digest_3;
   word_type digest_4;
   modport source (output valid, output digest_0, output digest_1, output digest_2,
                   output digest_3, output digest_4, input ready);
   modport sink (input valid, input digest_0, input digest_1, input digest_2,
                 input digest_3, input digest_4, output ready);
endinterface

@@ rtl/s0d_sched.sv @@
// Message schedule store: two mirrored 16-word synchronous memories giving four
// reads a cycle, with the expansion XOR and its write-back. Depends on s0d_pkg.
module s0d_sched (
   input  logic                clock,
   input  logic                reset,
   input  s0d_pkg::coll_wr_type coll_wr,
   input  logic                step,
   input  s0d_pkg::rnd_type    rd_rnd,
   output s0d_pkg::word_type   w_word
);
   import s0d_pkg::*;

   localparam int TAP_A = 3;
   localparam int TAP_B = 8;
   localparam int TAP_C = 14;

   word_type mem_a [BLOCK_WORDS];
   word_type mem_b [BLOCK_WORDS];

   word_type rd_a_ff;
   word_type rd_b_ff;
   word_type rd_c_ff;
   word_type rd_d_ff;
   addr_type wb_addr_ff;
   logic     expand_ff;

   addr_type addr_a;
   addr_type addr_b;
   addr_type addr_c;
   addr_type addr_d;
   logic     wb_en;
   logic     wr_en;
   addr_type wr_addr;
   word_type wr_data;

   // Addresses are those of the round about to run; the slot read as the
   // oldest tap is the one its expanded word later overwrites.
   assign addr_d = rd_rnd[ADDR_W-1:0];
   assign addr_a = addr_d - ADDR_W'(TAP_A);
   assign addr_b = addr_d - ADDR_W'(TAP_B);
   assign addr_c = addr_d - ADDR_W'(TAP_C);

   assign w_word = expand_ff ? (rd_a_ff ^ rd_b_ff ^ rd_c_ff ^ rd_d_ff) : rd_d_ff;

   assign wb_en   = step && expand_ff;
   assign wr_en   = coll_wr.wr_en || wb_en;
   assign wr_addr = coll_wr.wr_en ? coll_wr.wr_addr : wb_addr_ff;
   assign wr_data = coll_wr.wr_en ? coll_wr.wr_data : w_word;

   // A round writes slot i while the reads for round i+1 touch slots i-2,
   // i-7, i-13 and i+1, so reads and the write never meet on one entry.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_a[wr_addr] <= wr_data;
         mem_b[wr_addr] <= wr_data;
      end
      rd_a_ff    <= mem_a[addr_a];
      rd_b_ff    <= mem_a[addr_b];
      rd_c_ff    <= mem_b[addr_c];
      rd_d_ff    <= mem_b[addr_d];
      wb_addr_ff <= addr_d;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expand_ff <= 1'b0;
      end else begin
         expand_ff <= (rd_rnd >= RND_W'(BLOCK_WORDS));
      end
   end

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      wb_en |-> (wb_addr_ff != addr_a && wb_addr_ff != addr_b &&
                 wb_addr_ff != addr_c && wb_addr_ff != addr_d))
      else $error("schedule write-back meets a read on the same entry");

   a_no_write_clash: assert property (@(posedge clock) disable iff (reset)
      !(coll_wr.wr_en && step))
      else $error("message write during a compression round");

   a_round_advance: assert property (@(posedge clock) disable iff (reset)
      (step && $past(step)) |-> (rd_rnd == $past(rd_rnd) + RND_W'(1)))
      else $error("schedule read-ahead skipped a round");

endmodule

@@ rtl/s0d_round.sv @@
// Round datapath: working variables, chaining words and the final chain add.
// Depends on s0d_pkg for the constants and the control struct.
module s0d_round (
   input  logic                clock,
   input  logic                reset,
   input  s0d_pkg::rnd_ctl_type ctl,
   input  s0d_pkg::word_type   w_word,
   output s0d_pkg::chain_type  digest_sum
);
   import s0d_pkg::*;

   chain_type chain_ff;
   chain_type chain_in;
   chain_type var_ff;
   chain_type var_in;
   word_type  h_ff;
   word_type  h_in;
   word_type  f_val;
   word_type  t_val;

   // The rotate by five sign-fills the upper bits when the top bit is set.
   function automatic word_type rot5_signed(input word_type x);
      word_type r;
      r = {x[26:0], x[31:27]};
      if (x[31]) begin
         r = {27'h7ffffff, x[31:27]};
      end
      return r;
   endfunction

   // The rotate by thirty forces the top two bits when the top bit is set.
   function automatic word_type rot30_signed(input word_type x);
      word_type r;
      r = {x[1:0], x[31:2]};
      if (x[31]) begin
         r[31:30] = 2'b11;
      end
      return r;
   endfunction

   always_comb begin
      unique case (ctl.phase)
         PH_CHOOSE:   f_val = (var_ff[1] & var_ff[2]) | (~var_ff[1] & var_ff[3]);
         PH_MAJORITY: f_val = (var_ff[1] & var_ff[2]) | (var_ff[1] & var_ff[3]) |
                              (var_ff[2] & var_ff[3]);
         PH_PARITY_LO,
         PH_PARITY_HI: f_val = var_ff[1] ^ var_ff[2] ^ var_ff[3];
         default:     f_val = var_ff[1] ^ var_ff[2] ^ var_ff[3];
      endcase
   end

   // h_ff already carries e plus the round constant, prepared and registered ahead of the round.
   assign t_val = rot5_signed(var_ff[0]) + f_val + h_ff + w_word;

   always_comb begin
      for (int k = 0; k < CHAIN_WORDS; k++) begin
         digest_sum[k] = chain_ff[k] + var_ff[k];
      end
   end

   always_comb begin
      chain_in = chain_ff;
      var_in   = var_ff;
      h_in     = h_ff;
      if (ctl.restart) begin
         chain_in = INIT_CHAIN;
      end else if (ctl.finish) begin
         chain_in = digest_sum;
      end
      if (ctl.load) begin
         var_in = chain_ff;
         h_in   = chain_ff[4] + ROUND_K[ctl.phase_next];
      end else if (ctl.step) begin
         var_in[0] = t_val;
         var_in[1] = var_ff[0];
         var_in[2] = rot30_signed(var_ff[1]);
         var_in[3] = var_ff[2];
         var_in[4] = var_ff[3];
         h_in      = var_ff[3] + ROUND_K[ctl.phase_next];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= INIT_CHAIN;
      end else begin
         chain_ff <= chain_in;
      end
      var_ff <= var_in;
      h_ff   <= h_in;
   end

endmodule

@@ rtl/sha0_block_digest_signed_rotate.sv @@
// SHA-0 style block digest with sign-filling rotates: top level and sequencer.
// Depends on s0d_pkg, s0d_if, s0d_sched and s0d_round.
//
// Each op=1 beat stores one 32-bit message word, as given, into the schedule
// memory; the sixteenth word of a block starts the compression and the block
// then holds off requests through S_PREP, which reads ahead the first schedule
// words, S_ROUND, 80 rounds at one per cycle (four schedule reads from the two
// mirrored memories and the round adder each cycle), and S_FINISH, which adds
// the working variables into the chaining words and loads the response register
// once that register is free. The digest beat waits in its register while the
// next block is collected; only the end of the following compression stalls on
// it. An op=0 beat restores the initial chaining values, drops any partial block
// and returns nothing.
module sha0_block_digest_signed_rotate (
   input logic      clock,
   input logic      reset,
   s0d_req_if.sink   req_bus,
   s0d_rsp_if.source rsp_bus
);
   import s0d_pkg::*;

   typedef enum logic [1:0] {
      S_COLLECT,
      S_PREP,
      S_ROUND,
      S_FINISH
   } state_type;

   localparam rnd_type LAST_ROUND = RND_W'(ROUNDS - 1);

   state_type   state_ff;
   addr_type    count_ff;
   rnd_type     rnd_ff;
   logic        rsp_valid_ff;
   chain_type   rsp_digest_ff;

   logic        req_accept;
   logic        finish_go;
   rnd_type     rd_rnd;
   rnd_ctl_type ctl;
   coll_wr_type coll_wr;
   word_type    w_word;
   chain_type   digest_sum;

   assign req_bus.ready = (state_ff == S_COLLECT);
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign finish_go     = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_bus.ready);
   assign rd_rnd        = (state_ff == S_ROUND) ? rnd_ff + RND_W'(1) : '0;

   assign ctl.restart    = req_accept && (req_bus.op == OP_RESTART);
   assign ctl.load       = (state_ff == S_PREP);
   assign ctl.step       = (state_ff == S_ROUND);
   assign ctl.finish     = finish_go;
   assign ctl.phase      = round_phase(rnd_ff);
   assign ctl.phase_next = round_phase(rd_rnd);

   assign coll_wr.wr_en   = req_accept && (req_bus.op == OP_WORD);
   assign coll_wr.wr_addr = count_ff;
   assign coll_wr.wr_data = req_bus.msg_word;

   s0d_sched u_sched (
      .clock   (clock),
      .reset   (reset),
      .coll_wr (coll_wr),
      .step    (ctl.step),
      .rd_rnd  (rd_rnd),
      .w_word  (w_word)
   );

   s0d_round u_round (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .w_word     (w_word),
      .digest_sum (digest_sum)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_COLLECT;
         count_ff     <= '0;
         rnd_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (finish_go) begin
            rsp_valid_ff  <= 1'b1;
            rsp_digest_ff <= digest_sum;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_COLLECT: begin
               if (ctl.restart) begin
                  count_ff <= '0;
               end else if (coll_wr.wr_en) begin
                  count_ff <= count_ff + ADDR_W'(1);
                  if (count_ff == ADDR_W'(BLOCK_WORDS - 1)) begin
                     state_ff <= S_PREP;
                  end
               end
            end
            S_PREP: begin
               rnd_ff   <= '0;
               state_ff <= S_ROUND;
            end
            S_ROUND: begin
               rnd_ff <= rnd_ff + RND_W'(1);
               if (rnd_ff == LAST_ROUND) begin
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (finish_go) begin
                  state_ff <= S_COLLECT;
               end
            end
            default: begin
               state_ff <= S_COLLECT;
            end
         endcase
      end
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.digest_0 = rsp_digest_ff[0];
   assign rsp_bus.digest_1 = rsp_digest_ff[1];
   assign rsp_bus.digest_2 = rsp_digest_ff[2];
   assign rsp_bus.digest_3 = rsp_digest_ff[3];
   assign rsp_bus.digest_4 = rsp_digest_ff[4];

   a_last_round: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROUND && rnd_ff == LAST_ROUND) |=> (state_ff == S_FINISH))
      else $error("compression did not end after the last round");

   a_finish_shows: assert property (@(posedge clock) disable iff (reset)
      finish_go |=> rsp_valid_ff)
      else $error("finished block produced no response beat");

   a_block_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PREP) |-> (count_ff == '0))
      else $error("compression started on a partial block");

endmodule
